// ===== sv/hm45_pkg.sv =====
package hm45_pkg;

  localparam int TAPS         = 33;
  localparam int SAMPLE_WIDTH = 16;
  localparam int OUT_WIDTH    = 17;
  localparam int SUM_SHIFT    = 16;
  localparam int DIGIT_W      = 4;
  localparam int TAP_W        = 16;
  localparam int TAP_IDX_W    = 6;

  // Q15 taps; index 0 meets the newest sample.
  function automatic logic signed [TAP_W-1:0] tap_coef(input logic [TAP_IDX_W-1:0] idx);
    logic signed [TAP_W-1:0] c;
    case (idx)
      6'd0:    c = 16'sd43;
      6'd1:    c = 16'sd5;
      6'd2:    c = 16'sd126;
      6'd3:    c = -16'sd28;
      6'd4:    c = 16'sd274;
      6'd5:    c = -16'sd144;
      6'd6:    c = 16'sd493;
      6'd7:    c = -16'sd416;
      6'd8:    c = 16'sd771;
      6'd9:    c = -16'sd960;
      6'd10:   c = 16'sd1073;
      6'd11:   c = -16'sd2001;
      6'd12:   c = 16'sd1349;
      6'd13:   c = -16'sd4287;
      6'd14:   c = 16'sd1542;
      6'd15:   c = -16'sd14525;
      6'd16:   c = -16'sd21550;
      6'd17:   c = 16'sd14525;
      6'd18:   c = 16'sd1542;
      6'd19:   c = 16'sd4287;
      6'd20:   c = 16'sd1349;
      6'd21:   c = 16'sd2001;
      6'd22:   c = 16'sd1073;
      6'd23:   c = 16'sd960;
      6'd24:   c = 16'sd771;
      6'd25:   c = 16'sd416;
      6'd26:   c = 16'sd493;
      6'd27:   c = 16'sd144;
      6'd28:   c = 16'sd274;
      6'd29:   c = 16'sd28;
      6'd30:   c = 16'sd126;
      6'd31:   c = -16'sd5;
      6'd32:   c = 16'sd43;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/hilbert_minus45_fir.sv =====
// Channel   Direction  Signals
// sample    in         in_valid_i, in_stall_o, sample_in_i
// result    out        out_valid_o, out_stall_i, filtered_out_o
//
// A sample runs all taps once per 4-bit digit; the next waits until its result is loaded.
// A single 16 x 4 bit multiply-accumulate handles one tap and one 4-bit sample digit per cycle.
// Reset clears the sample history, the controller and the result register.
// A result held by out_stall_i does not block the next sample from being taken.
module hilbert_minus45_fir #(
  parameter int SAMPLE_WIDTH = hm45_pkg::SAMPLE_WIDTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [hm45_pkg::OUT_WIDTH-1:0] filtered_out_o
);

  localparam int NumDigits = (SAMPLE_WIDTH + hm45_pkg::DIGIT_W - 1) / hm45_pkg::DIGIT_W;
  localparam int DigW      = (NumDigits > 1) ? $clog2(NumDigits) : 1;
  localparam int XW        = NumDigits * hm45_pkg::DIGIT_W;
  localparam int ProdW     = hm45_pkg::TAP_W + hm45_pkg::DIGIT_W + 1;
  localparam int AccMin    = hm45_pkg::SUM_SHIFT + hm45_pkg::OUT_WIDTH;
  localparam int AccW      = (XW + 18 > AccMin) ? XW + 18 : AccMin;
  localparam int TW        = hm45_pkg::TAP_IDX_W;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StFinish
  } state_e;

  state_e                                state_q;
  logic signed [SAMPLE_WIDTH-1:0]        hist_q [hm45_pkg::TAPS];
  logic [TW-1:0]                         tap_q;
  logic [DigW-1:0]                       dig_q;
  logic signed [AccW-1:0]                acc_q;
  logic signed [AccW-1:0]                acc_d;
  logic                                  out_valid_q;
  logic signed [hm45_pkg::OUT_WIDTH-1:0] out_q;

  logic                                  in_xfer;
  logic                                  out_free;
  logic signed [XW-1:0]                  xs;
  logic [hm45_pkg::DIGIT_W-1:0]          digit;
  logic signed [hm45_pkg::DIGIT_W:0]     digit_s;
  logic signed [hm45_pkg::TAP_W-1:0]     coef;
  logic signed [ProdW-1:0]               prod;

  assign in_stall_o     = (state_q != StIdle);
  assign in_xfer        = in_valid_i && !in_stall_o;
  assign out_free       = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign filtered_out_o = out_q;

  assign xs      = XW'(hist_q[0]);
  assign digit   = xs[dig_q * hm45_pkg::DIGIT_W +: hm45_pkg::DIGIT_W];
  assign digit_s = (dig_q == DigW'(NumDigits - 1)) ? {digit[hm45_pkg::DIGIT_W-1], digit}
                                                   : {1'b0, digit};
  assign coef    = hm45_pkg::tap_coef(tap_q);
  assign prod    = coef * digit_s;

  // Digits go most significant first, so the sum is shifted one digit at the start of each pass.
  always_comb begin
    if (tap_q == '0) begin
      acc_d = (acc_q <<< hm45_pkg::DIGIT_W) + AccW'(prod);
    end else begin
      acc_d = acc_q + AccW'(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tap_q       <= '0;
      dig_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < hm45_pkg::TAPS; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != StFinish)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_xfer) begin
            hist_q[0] <= sample_in_i;
            for (int i = 1; i < hm45_pkg::TAPS; i++) begin
              hist_q[i] <= hist_q[i-1];
            end
            tap_q   <= '0;
            dig_q   <= DigW'(NumDigits - 1);
            acc_q   <= '0;
            state_q <= StRun;
          end
        end
        StRun: begin
          acc_q <= acc_d;
          for (int i = 0; i < hm45_pkg::TAPS - 1; i++) begin
            hist_q[i] <= hist_q[i+1];
          end
          hist_q[hm45_pkg::TAPS-1] <= hist_q[0];
          if (tap_q == TW'(hm45_pkg::TAPS - 1)) begin
            tap_q <= '0;
            if (dig_q == '0) begin
              state_q <= StFinish;
            end else begin
              dig_q <= dig_q - 1'b1;
            end
          end else begin
            tap_q <= tap_q + 1'b1;
          end
        end
        StFinish: begin
          if (out_free) begin
            out_q       <= acc_q[AccMin-1:hm45_pkg::SUM_SHIFT];
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  a_tap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_q < TW'(hm45_pkg::TAPS))
    else $error("tap counter out of range");

  a_sample_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == StRun) && (hist_q[0] == $past(sample_in_i)) && (tap_q == '0))
    else $error("accepted sample not at head of history");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish) && out_free |=>
      out_valid_o && (filtered_out_o == $past(acc_q[AccMin-1:hm45_pkg::SUM_SHIFT])))
    else $error("finished sum not transferred to result register");

endmodule

// ===== test/tb.sv =====
typedef logic signed [hm45_pkg::SAMPLE_WIDTH-1:0] sample_t;
typedef logic signed [hm45_pkg::OUT_WIDTH-1:0] filt_t;

class hilbert_out_tracker;
  int      tap_q15[hm45_pkg::TAPS];
  sample_t history[hm45_pkg::TAPS];
  int      write_slot;
  filt_t   expected_out[$];
  int      checked_cnt;
  int      mismatch_cnt;

  function new();
    tap_q15 = '{
         43,      5,    126,    -28,    274,   -144,    493,   -416,
        771,   -960,   1073,  -2001,   1349,  -4287,   1542, -14525,
     -21550,  14525,   1542,   4287,   1349,   2001,   1073,    960,
        771,    416,    493,    144,    274,     28,    126,     -5,
         43};
    foreach (history[i]) history[i] = '0;
    write_slot   = 0;
    checked_cnt  = 0;
    mismatch_cnt = 0;
  endfunction

  // The newest sample meets tap 0; the sum is floored by an arithmetic shift.
  function void add_sample(sample_t s);
    longint acc;
    longint q;
    int     idx;
    history[write_slot] = s;
    write_slot = (write_slot == hm45_pkg::TAPS - 1) ? 0 : write_slot + 1;
    acc = 0;
    idx = write_slot;
    for (int i = 0; i < hm45_pkg::TAPS; i++) begin
      idx = (idx != 0) ? idx - 1 : hm45_pkg::TAPS - 1;
      acc += longint'(history[idx]) * longint'(tap_q15[i]);
    end
    q = acc >>> hm45_pkg::SUM_SHIFT;
    expected_out.push_back(q[hm45_pkg::OUT_WIDTH-1:0]);
  endfunction

  function void check_out(filt_t got);
    filt_t want;
    if (expected_out.size() == 0) begin
      $error("filtered_out: no result expected, got %0d", got);
      mismatch_cnt++;
      return;
    end
    want = expected_out.pop_front();
    checked_cnt++;
    if (got !== want) begin
      $error("filtered_out: expected %0d, actual %0d", want, got);
      mismatch_cnt++;
    end
  endfunction
endclass

module tb;
  localparam int RANDOM_ITEMS = 800;
  localparam int HOLD_CYCLES  = 1500;
  localparam int IDLE_LIMIT   = 20000;
  localparam int N_DIRECTED   = 20;
  localparam sample_t DIRECTED[N_DIRECTED] = '{
    16'sd0, 16'sd32767, 16'sd0, -16'sd32768, 16'sd0, -16'sd1, 16'sd1, 16'sh5555,
    16'shAAAA, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd256,
    -16'sd256, 16'sd12345, -16'sd12345, 16'sh7FFE, 16'sh8001, 16'sd0};

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  sample_t sample_in;
  logic    out_valid;
  logic    out_stall;
  filt_t   filtered_out;

  hilbert_out_tracker trk;
  int samples_fed;
  int idle_cycles;

  hilbert_minus45_fir dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_in_i    (sample_in),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .filtered_out_o (filtered_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(100, 400);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(input sample_t s, input int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    sample_in = s;
    do @(posedge clk); while (in_stall);
    trk.add_sample(s);
    samples_fed++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) trk.check_out(filtered_out);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timed out after %0d cycles without a transfer.", idle_cycles);
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int  stall_left;
    int  run_left;
    bit  held;
    stall_left = 0;
    run_left   = 0;
    held       = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held && trk.checked_cnt >= 100) begin
        held      = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (run_left > 0) begin
        out_stall = 1'b0;
        run_left--;
      end else begin
        out_stall  = 1'b0;
        stall_left = pick_gap();
        run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(300, 1500)
                                                 : $urandom_range(1, 60);
      end
    end
  end

  initial begin
    int      mode;
    int      len;
    int      n;
    bit      polar;
    sample_t s;
    sample_t hold_val;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    sample_in   = '0;
    out_stall   = 1'b0;
    samples_fed = 0;
    idle_cycles = 0;
    trk = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) send_sample(DIRECTED[i], pick_gap());

    n = 0;
    while (n < RANDOM_ITEMS) begin
      mode     = $urandom_range(0, 9);
      polar    = $urandom_range(0, 1);
      hold_val = sample_t'($urandom);
      case (mode)
        4, 5:    len = hm45_pkg::TAPS;
        8:       len = hm45_pkg::TAPS + 1;
        default: len = $urandom_range(1, 40);
      endcase
      for (int k = 0; k < len; k++) begin
        case (mode)
          4, 5: begin
            // Full-scale run whose signs line up with the taps at its last output.
            if ((trk.tap_q15[hm45_pkg::TAPS - 1 - k] >= 0) ^ polar) s = 16'sd32767;
            else s = -16'sd32768;
          end
          6: s = sample_t'(int'($urandom_range(0, 31)) - 16);
          7: begin
            case ($urandom_range(0, 4))
              0:       s = 16'sd32767;
              1:       s = -16'sd32768;
              2:       s = 16'sd0;
              3:       s = -16'sd1;
              default: s = 16'sd1;
            endcase
          end
          8: s = (k != 0) ? 16'sd0 : (polar ? -16'sd32768 : 16'sd32767);
          9: s = hold_val;
          default: s = sample_t'($urandom);
        endcase
        send_sample(s, pick_gap());
      end
      n += len;
    end
    in_valid = 1'b0;

    while (trk.expected_out.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Fed %0d samples (directed, full-scale, impulse and random runs), checked %0d outputs.",
             samples_fed, trk.checked_cnt);
    $display("Output held off for %0d cycles once with input still offered; %0d mismatches.",
             HOLD_CYCLES, trk.mismatch_cnt);
    if (trk.mismatch_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
